// ===== src/gpr_pkg.sv =====
// Shared constants for the Gaussian pyramid reduce block.
// Field widths, register indexes and reset values; no dependencies.
package gpr_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT        = 4096;

   localparam int PIX_W        = 8;
   localparam int SRC_WIDTH_W  = 11;
   localparam int SRC_HEIGHT_W = 13;
   localparam int ROW_W        = 12;
   localparam int OUT_COL_W    = 9;
   localparam int OUT_ROW_W    = 11;
   localparam int VSUM_W       = 10;
   localparam int HSUM_W       = 12;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;

   localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RESET  = 11'd640;
   localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RESET = 13'd480;

endpackage

// ===== src/gaussian_pyramid_reduce.sv =====
// Gaussian pyramid reduce, 3x3 binomial kernel, one source pixel per request; uses gpr_pkg.
// Path: stage 1 registers each accepted pixel, the output register each firing one.
// Throughput: 1 pixel per cycle unless results stall; the line memory is read at the
// request, written back as stage 1 advances, bypassed if the next request hits that column.
// Reset: counters and column taps to 0, size to 640x480; the line memory is not
// cleared and is undefined until written.
module gaussian_pyramid_reduce #(
   parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = pixel_in[7:0]; tuser = frame_start
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gpr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   // result: tdata = pixel_out[7:0], out_col[16:8], out_row[27:17], zero[31:28]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gpr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gpr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gpr_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW0 = $clog2(MAX_WIDTH + 1);
   localparam int WW  = (WW0 > gpr_pkg::SRC_WIDTH_W) ? WW0 : gpr_pkg::SRC_WIDTH_W;
   localparam int PW  = gpr_pkg::PIX_W;
   localparam int RW  = gpr_pkg::ROW_W;
   localparam int HW  = gpr_pkg::SRC_HEIGHT_W;
   localparam int OCW = gpr_pkg::OUT_COL_W;

   // configuration
   logic [gpr_pkg::SRC_WIDTH_W-1:0]  src_width_ff;
   logic [gpr_pkg::SRC_HEIGHT_W-1:0] src_height_ff;
   logic [WW-1:0] w_ext, w_eff;
   logic [HW-1:0] h_eff;
   logic [CW-1:0] w_last;
   logic [RW-1:0] h_last;

   // position counters
   logic [CW-1:0] col_count_ff, col_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] c_cur;
   logic [RW-1:0] r_cur;
   logic          last_col, last_row;
   logic          req_fire;

   // pipeline stage
   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic [PW-1:0] s1_pix_ff;
   logic          s1_lastc_ff, s1_lastr_ff;
   logic          s1_fire, s1_advance;

   // line memory: {older, newer} per column
   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] line_rd_ff;
   logic            byp_valid_ff;
   logic [2*PW-1:0] byp_data_ff;
   logic [2*PW-1:0] line_cur;
   logic [PW-1:0]   older_d, newer_d;

   // arithmetic
   logic [PW-1:0] top, mid, bot;
   logic [gpr_pkg::VSUM_W-1:0] v;
   logic [gpr_pkg::VSUM_W-1:0] taps0_ff, taps1_ff;
   logic [gpr_pkg::VSUM_W-1:0] left, centre, right;
   logic [gpr_pkg::HSUM_W-1:0] hsum;

   // output register
   logic                          rsp_tvalid_ff;
   logic [PW-1:0]                 rsp_pix_ff;
   logic [gpr_pkg::OUT_COL_W-1:0] rsp_col_ff;
   logic [gpr_pkg::OUT_ROW_W-1:0] rsp_row_ff;
   logic                          rsp_last_ff;

   // ---- size clamping ----
   always_comb begin
      w_ext = WW'(src_width_ff);
      if (w_ext < WW'(2)) begin
         w_eff = WW'(2);
      end else if (w_ext > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      if (src_height_ff < HW'(2)) begin
         h_eff = HW'(2);
      end else if (src_height_ff > HW'(gpr_pkg::MAX_HEIGHT)) begin
         h_eff = HW'(gpr_pkg::MAX_HEIGHT);
      end else begin
         h_eff = src_height_ff;
      end
   end

   assign w_last = CW'(w_eff - WW'(1));
   assign h_last = RW'(h_eff - HW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= gpr_pkg::SRC_WIDTH_RESET;
         src_height_ff <= gpr_pkg::SRC_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            gpr_pkg::REG_SRC_WIDTH: begin
               src_width_ff <= csr_data[gpr_pkg::SRC_WIDTH_W-1:0];
            end
            gpr_pkg::REG_SRC_HEIGHT: begin
               src_height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // ---- request side: position and memory read ----
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      c_cur    = req_tuser ? '0 : col_count_ff;
      r_cur    = req_tuser ? '0 : row_count_ff;
      last_col = c_cur >= w_last;
      last_row = r_cur >= h_last;
      if (last_col) begin
         col_count_in = '0;
         row_count_in = last_row ? '0 : r_cur + RW'(1);
      end else begin
         col_count_in = c_cur + CW'(1);
         row_count_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            col_count_ff <= col_count_in;
            row_count_ff <= row_count_in;
            byp_valid_ff <= s1_advance && (s1_col_ff == c_cur);
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_col_ff   <= c_cur;
         s1_row_ff   <= r_cur;
         s1_pix_ff   <= req_tdata[PW-1:0];
         s1_lastc_ff <= last_col;
         s1_lastr_ff <= last_row;
         byp_data_ff <= {newer_d, s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         line_mem[s1_col_ff] <= {newer_d, s1_pix_ff};
      end
      if (req_fire) begin
         line_rd_ff <= line_mem[c_cur];
      end
   end

   // ---- stage 1: window sums and write-back ----
   assign line_cur = byp_valid_ff ? byp_data_ff : line_rd_ff;
   assign older_d  = line_cur[2*PW-1:PW];
   assign newer_d  = line_cur[PW-1:0];

   always_comb begin
      if (s1_row_ff[0]) begin
         mid = newer_d;
         top = (s1_row_ff == RW'(1)) ? newer_d : older_d;
         bot = s1_pix_ff;
      end else begin
         top = newer_d;
         mid = s1_pix_ff;
         bot = s1_pix_ff;
      end
      v = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, bot};

      if (s1_col_ff[0]) begin
         centre = taps0_ff;
         left   = (s1_col_ff == CW'(1)) ? taps0_ff : taps1_ff;
         right  = v;
      end else begin
         left   = taps0_ff;
         centre = v;
         right  = v;
      end
      hsum = {2'b00, left} + {1'b0, centre, 1'b0} + {2'b00, right};
   end

   assign s1_fire    = (s1_row_ff[0] || s1_lastr_ff) && (s1_col_ff[0] || s1_lastc_ff);
   assign s1_advance = s1_valid_ff && (!s1_fire || !rsp_tvalid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         taps0_ff      <= '0;
         taps1_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (s1_advance) begin
            taps1_ff <= taps0_ff;
            taps0_ff <= v;
         end
         if (s1_advance && s1_fire) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_fire) begin
         rsp_pix_ff  <= hsum[gpr_pkg::HSUM_W-1:4];
         rsp_col_ff  <= OCW'(s1_col_ff >> 1);
         rsp_row_ff  <= s1_row_ff[gpr_pkg::OUT_ROW_W:1];
         rsp_last_ff <= s1_lastc_ff && s1_lastr_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_row_ff, rsp_col_ff, rsp_pix_ff};

   // ---- checks ----
   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_fire) |=> rsp_tvalid_ff)
      else $error("firing pixel did not reach the output register");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(s1_advance && s1_fire))
      else $error("result appeared without a firing pixel");

   a_col_sequence: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser && col_count_ff != '0) |-> (col_count_ff == s1_col_ff + CW'(1)))
      else $error("column counter skipped a position");

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for gaussian_pyramid_reduce: random and directed pixel requests
// at several frame sizes, checked against a bit-true reduce predictor.
// Depends on gpr_pkg and the gaussian_pyramid_reduce RTL.

typedef struct packed {
   logic [3:0]                    pad;
   logic [gpr_pkg::OUT_ROW_W-1:0] row;
   logic [gpr_pkg::OUT_COL_W-1:0] col;
   logic [gpr_pkg::PIX_W-1:0]     pix;
} reduced_word_type;

typedef struct {
   reduced_word_type word;
   logic             eof;
} reduced_px_type;

class reduce_scoreboard;
   bit [gpr_pkg::PIX_W-1:0]        line_older [gpr_pkg::MAX_WIDTH_DEFAULT];
   bit [gpr_pkg::PIX_W-1:0]        line_newer [gpr_pkg::MAX_WIDTH_DEFAULT];
   int unsigned                    vsum_prev;
   int unsigned                    vsum_prev2;
   int unsigned                    col_cnt;
   int unsigned                    row_cnt;
   bit [gpr_pkg::SRC_WIDTH_W-1:0]  width_reg;
   bit [gpr_pkg::SRC_HEIGHT_W-1:0] height_reg;
   reduced_px_type                 expected_px [$];
   int                             pixels_seen;
   int                             results_seen;
   int                             errors;

   function new();
      width_reg    = gpr_pkg::SRC_WIDTH_RESET;
      height_reg   = gpr_pkg::SRC_HEIGHT_RESET;
      vsum_prev    = 0;
      vsum_prev2   = 0;
      col_cnt      = 0;
      row_cnt      = 0;
      pixels_seen  = 0;
      results_seen = 0;
      errors       = 0;
   endfunction

   function void write_reg(logic [gpr_pkg::CSR_INDEX_W-1:0] index,
                           logic [gpr_pkg::CSR_DATA_W-1:0] data);
      if (index == gpr_pkg::REG_SRC_WIDTH) begin
         width_reg = data[gpr_pkg::SRC_WIDTH_W-1:0];
      end else if (index == gpr_pkg::REG_SRC_HEIGHT) begin
         height_reg = data;
      end
   endfunction

   function int pending();
      return expected_px.size();
   endfunction

   // one source pixel in; queues the reduced pixel it completes, if any
   function void note_pixel(logic [gpr_pkg::PIX_W-1:0] pix, logic sof);
      int unsigned w, h, c, r, older, newer, top, mid, bot, v;
      int unsigned left, centre, right, sum;
      bit          last_col, last_row, fire_row, fire_col;
      bit [$clog2(gpr_pkg::MAX_WIDTH_DEFAULT)-1:0] ci;
      reduced_px_type px;
      w = 32'(width_reg);
      h = 32'(height_reg);
      if (w < 2) w = 2;
      if (w > gpr_pkg::MAX_WIDTH_DEFAULT) w = gpr_pkg::MAX_WIDTH_DEFAULT;
      if (h < 2) h = 2;
      if (h > gpr_pkg::MAX_HEIGHT) h = gpr_pkg::MAX_HEIGHT;
      if (sof) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      c = col_cnt;
      r = row_cnt;
      ci = c[$clog2(gpr_pkg::MAX_WIDTH_DEFAULT)-1:0];
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      older = 32'(line_older[ci]);
      newer = 32'(line_newer[ci]);
      line_older[ci] = line_newer[ci];
      line_newer[ci] = pix;
      fire_row = r[0] || last_row;
      if (r[0]) begin
         mid = newer;
         top = (r == 1) ? newer : older;
         bot = 32'(pix);
      end else begin
         // even last row: row below replicated
         top = newer;
         mid = 32'(pix);
         bot = 32'(pix);
      end
      v = top + 2 * mid + bot;
      fire_col = c[0] || last_col;
      if (fire_row && fire_col) begin
         if (c[0]) begin
            centre = vsum_prev;
            left   = (c == 1) ? centre : vsum_prev2;
            right  = v;
         end else begin
            left   = vsum_prev;
            centre = v;
            right  = v;
         end
         sum = left + 2 * centre + right;
         px.word.pad = '0;
         px.word.pix = sum[gpr_pkg::PIX_W+3:4];
         px.word.col = c[gpr_pkg::OUT_COL_W:1];
         px.word.row = r[gpr_pkg::OUT_ROW_W:1];
         px.eof      = last_col && last_row;
         expected_px = {expected_px, px};
      end
      vsum_prev2 = vsum_prev;
      vsum_prev  = v;
      if (last_col) begin
         col_cnt = 0;
         row_cnt = last_row ? 0 : ((r + 1) & 32'hFFF);
      end else begin
         col_cnt = (c + 1) & 32'h3FF;
      end
      pixels_seen++;
   endfunction

   function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 40)
         $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
   endfunction

   function void check_result(logic [gpr_pkg::RSP_TDATA_W-1:0] data, logic last);
      reduced_word_type got;
      reduced_px_type   want;
      got = data;
      results_seen++;
      if (expected_px.size() == 0) begin
         errors++;
         if (errors <= 40)
            $display("%0t unexpected result: expected none, got tdata %0h tlast %0b",
                     $time, data, last);
         return;
      end
      want = expected_px.pop_front();
      if (got.pix !== want.word.pix)
         report("pixel_out", 32'(want.word.pix), 32'(got.pix));
      if (got.col !== want.word.col)
         report("out_col", 32'(want.word.col), 32'(got.col));
      if (got.row !== want.word.row)
         report("out_row", 32'(want.word.row), 32'(got.row));
      if (got.pad !== want.word.pad)
         report("tdata pad", 32'(want.word.pad), 32'(got.pad));
      if (last !== want.eof) report("end_of_frame", 32'(want.eof), 32'(last));
   endfunction
endclass

module tb;

   localparam int RESET_CYCLES    = 2;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int DRAIN_SETTLE    = 4;
   localparam int ITEM_TARGET     = 1850;
   localparam logic [gpr_pkg::CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [gpr_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [gpr_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [gpr_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [gpr_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   reduce_scoreboard sb;
   int               req_idle_pct;
   int               rsp_idle_pct;
   bit               rsp_hold_req;
   int               sent_pixels;
   int               phases;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gaussian_pyramid_reduce u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic int idle_choice();
      unique case ($urandom_range(0, 3))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 50;
      endcase
   endfunction

   function automatic logic [gpr_pkg::PIX_W-1:0] rand_pixel();
      unique case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [gpr_pkg::PIX_W-1:0] pix, input logic sof);
      int gap;
      gap = ($urandom_range(0, 99) < req_idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= sof;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(pix, sof);
      sent_pixels++;
   endtask

   task automatic send_run(input int count, input bit sof_first);
      for (int i = 0; i < count; i++)
         send_pixel(rand_pixel(), sof_first && (i == 0));
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [gpr_pkg::CSR_INDEX_W-1:0] index,
                            input logic [gpr_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_size(input int unsigned w, input int unsigned h);
      wait_drain();
      csr_write(gpr_pkg::REG_SRC_WIDTH, w[gpr_pkg::CSR_DATA_W-1:0]);
      csr_write(gpr_pkg::REG_SRC_HEIGHT, h[gpr_pkg::CSR_DATA_W-1:0]);
   endtask

   // result side: random back-pressure plus one long hold-off on request
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall_left   = RSP_HOLD_CYCLES;
         end
         if (stall_left == 0 && $urandom_range(0, 99) < rsp_idle_pct) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int unsigned w, h, w_eff, h_eff, frames, count, cut;
      bit          sof;
      sb           = new();
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      rsp_hold_req = 1'b0;
      sent_pixels  = 0;
      phases       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: one full 640-wide row, then the first result of row 1
      send_run(int'(gpr_pkg::SRC_WIDTH_RESET) + 2, 1'b1);

      // clamped to 2x2, spare index ignored, then overrun without frame start
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_size(0, 1);
      csr_write(REG_SPARE, '1);
      for (int i = 0; i < 4; i++) send_pixel(8'hFF, i == 0);
      for (int i = 0; i < 4; i++) send_pixel(8'h00, 1'b0);

      // odd size: last column and last row are even
      set_size(3, 3);
      for (int i = 0; i < 9; i++) send_pixel(i[0] ? 8'hFF : 8'h00, i == 0);

      // shrink width, then height, in mid-frame
      set_size(4, 5);
      send_run(6, 1'b1);
      set_size(2, 5);
      send_pixel(8'hFF, 1'b0);
      set_size(2, 2);
      send_pixel(8'h00, 1'b0);

      // widest row, clamped from an all-ones width, up to the first result of row 1
      req_idle_pct = 5;
      rsp_idle_pct = 5;
      set_size(2047, 2);
      send_run(gpr_pkg::MAX_WIDTH_DEFAULT + 2, 1'b1);

      while (sent_pixels < ITEM_TARGET) begin
         unique case ($urandom_range(0, 9))
            0: w = $urandom_range(0, 1);
            1: w = $urandom_range(21, 64);
            default: w = $urandom_range(2, 20);
         endcase
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
         if (phases == 0) begin
            w = 16;
            h = 8;
         end
         w_eff = (w < 2) ? 2 : w;
         h_eff = (h < 2) ? 2 : h;
         set_size(w, h);
         req_idle_pct = idle_choice();
         rsp_idle_pct = idle_choice();
         if (phases == 0) begin
            // back-to-back requests into a long result stall
            req_idle_pct = 0;
            rsp_hold_req = 1'b1;
         end
         frames = $urandom_range(1, 3);
         sof = 1'b1;
         for (int f = 0; f < frames; f++) begin
            if (sent_pixels >= ITEM_TARGET) break;
            count = w_eff * h_eff;
            if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count - 1);
            if (count > ITEM_TARGET - sent_pixels) count = ITEM_TARGET - sent_pixels;
            if (count > 1 && (phases == 1 || $urandom_range(0, 5) == 0)) begin
               cut = $urandom_range(1, count - 1);
               send_run(cut, sof);
               wait_drain();
               send_run(count - cut, 1'b0);
            end else begin
               send_run(count, sof);
            end
            // cut frames restart with frame start; full ones may overrun
            sof = (count < w_eff * h_eff) || ($urandom_range(0, 3) != 0);
         end
         phases++;
      end
      wait_drain();

      $display("Covered %0d pixel requests, %0d reduced pixels, %0d random size phases,",
               sb.pixels_seen, sb.results_seen, phases);
      $display("plus clamped, odd, mid-frame resize and 1024-wide frames.");
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
